>>> hdl/lcrs_pkg.sv
// lcrs_pkg: shared types and constants for the largest colour region block
// used by lcrs_cell and largest_colour_region_size, depends on nothing
`timescale 1ns / 1ps

package lcrs_pkg;

    localparam int NODE_COUNT_DEF   = 32;
    localparam int COLOUR_COUNT_DEF = 8;

    localparam int INDEX_W  = 5;
    localparam int COLOUR_W = 3;
    localparam int MASK_W   = 32;
    localparam int SIZE_W   = 6;
    localparam int REQ_W    = 2;
    localparam int IN_W     = INDEX_W + COLOUR_W + MASK_W;
    localparam int IN_DATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SIZE_W + 7) / 8) * 8;

    localparam logic [SIZE_W-1:0] SIZE_SAT = '1;

    localparam logic [REQ_W-1:0] REQ_WR_COLOUR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_ROW    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY     = 2'd2;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                wr_colour;
        logic                wr_row;
        logic                start;
        logic                mark;
        logic [INDEX_W-1:0]  node_index;
        logic [COLOUR_W-1:0] colour;
    } bus_t;

    // flags of the flood token walking down the chain
    typedef struct packed {
        logic valid;
        logic seeded;
        logic changed;
    } tok_t;

endpackage

>>> hdl/largest_colour_region_size.sv
// largest_colour_region_size: top level with the request controller and the cell chain
// uses lcrs_pkg and lcrs_cell
`timescale 1ns / 1ps

// usage
//   s_axis carries requests: tuser is the request kind, tdata the node index,
//   colour and neighbour mask. colour and row writes give no result. a query
//   gives one transaction on m_axis with the size of the largest region of
//   nodes of that colour, 0 when no node has it.
// query passes
//   a query sends a flood token down the chain of NODE_COUNT cells, one cell
//   a cycle. each pass either finds a new seed or widens the current region; a
//   region is done after a pass that adds nothing behind the token, and a last
//   pass finds no seed. there is one pass per region, one more each time a pass
//   reaches a node behind the token, and the last one; s_axis is not ready
//   while a query runs.
// reset
//   rst_n clears every colour to 0 and every row to no edges, and drops any
//   pending result.
// stalls
//   a finished result waits in the output register; writes and a new query
//   are still taken meanwhile, and a second query holds its answer until the
//   output register is free.
module largest_colour_region_size #(
    parameter int NODE_COUNT   = lcrs_pkg::NODE_COUNT_DEF,
    parameter int COLOUR_COUNT = lcrs_pkg::COLOUR_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // from bit 0: node_index[4:0], colour[7:5], neighbour_mask[39:8]
    input  logic [lcrs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // from bit 0: req_type[1:0]
    input  logic [lcrs_pkg::REQ_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // from bit 0: region_size[5:0]
    output logic [lcrs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int CNT_W    = $clog2(NODE_COUNT + 1);
    localparam int WIDE_W   = (NODE_COUNT > lcrs_pkg::MASK_W) ? NODE_COUNT : lcrs_pkg::MASK_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    lcrs_pkg::tok_t         inj_tok_reg, inj_tok_next;
    logic [NODE_COUNT-1:0]  inj_reach_reg, inj_reach_next;
    logic [lcrs_pkg::SIZE_W-1:0] best_reg, best_next;
    logic                   out_valid_reg, out_valid_next;
    logic [lcrs_pkg::SIZE_W-1:0] out_data_reg, out_data_next;

    logic                          in_accept;
    logic [lcrs_pkg::INDEX_W-1:0]  in_index;
    logic [lcrs_pkg::COLOUR_W-1:0] in_colour;
    logic [lcrs_pkg::MASK_W-1:0]   in_mask;
    logic [WIDE_W-1:0]             mask_wide;
    logic [NODE_COUNT-1:0]         wr_row;
    lcrs_pkg::bus_t                bus;
    logic                          index_ok;
    logic                          colour_ok;

    lcrs_pkg::tok_t        tok   [0:NODE_COUNT];
    logic [NODE_COUNT-1:0] reach [0:NODE_COUNT];
    logic [CNT_W-1:0]      cnt   [0:NODE_COUNT];

    lcrs_pkg::tok_t        tok_last;
    logic [NODE_COUNT-1:0] reach_last;
    logic [CNT_W-1:0]      cnt_last;
    logic                  region_done;
    logic [lcrs_pkg::SIZE_W-1:0] region_size;

    assign in_index  = s_axis_tdata[lcrs_pkg::INDEX_W-1:0];
    assign in_colour = s_axis_tdata[lcrs_pkg::INDEX_W +: lcrs_pkg::COLOUR_W];
    assign in_mask   = s_axis_tdata[lcrs_pkg::INDEX_W + lcrs_pkg::COLOUR_W +: lcrs_pkg::MASK_W];
    assign mask_wide = WIDE_W'(in_mask);
    assign wr_row    = mask_wide[NODE_COUNT-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign index_ok      = (int'(in_index) < NODE_COUNT);
    assign colour_ok     = (int'(in_colour) < COLOUR_COUNT);

    assign tok_last    = tok[NODE_COUNT];
    assign reach_last  = reach[NODE_COUNT];
    assign cnt_last    = cnt[NODE_COUNT];
    // token back with a seed and nothing added behind it: region complete
    assign region_done = (state_reg == ST_RUN) & tok_last.valid & tok_last.seeded
                         & ~tok_last.changed;
    assign region_size = (int'(cnt_last) > int'(lcrs_pkg::SIZE_SAT)) ?
                         lcrs_pkg::SIZE_SAT : lcrs_pkg::SIZE_W'(cnt_last);

    always_comb
    begin
        bus.wr_colour  = in_accept & (s_axis_tuser == lcrs_pkg::REQ_WR_COLOUR)
                         & index_ok & colour_ok;
        bus.wr_row     = in_accept & (s_axis_tuser == lcrs_pkg::REQ_WR_ROW) & index_ok;
        bus.start      = in_accept & (s_axis_tuser == lcrs_pkg::REQ_QUERY);
        bus.mark       = region_done;
        bus.node_index = in_index;
        bus.colour     = in_colour;
    end

    assign tok[0]   = inj_tok_reg;
    assign reach[0] = inj_reach_reg;
    assign cnt[0]   = '0;

    genvar g;
    generate
        for (g = 0; g < NODE_COUNT; g++)
        begin : g_cell
            lcrs_cell #(
                .NODE_COUNT (NODE_COUNT),
                .CNT_W      (CNT_W),
                .IDX        (g)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .bus        (bus),
                .wr_row     (wr_row),
                .mark_reach (reach_last),
                .tok_in     (tok[g]),
                .reach_in   (reach[g]),
                .count_in   (cnt[g]),
                .tok_out    (tok[g+1]),
                .reach_out  (reach[g+1]),
                .count_out  (cnt[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        inj_tok_next   = '0;
        inj_reach_next = '0;
        best_next      = best_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (bus.start)
                begin
                    inj_tok_next.valid = 1'b1;
                    best_next          = '0;
                    state_next         = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (tok_last.valid)
                begin
                    if (!tok_last.seeded)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (tok_last.changed)
                    begin
                        inj_tok_next.valid  = 1'b1;
                        inj_tok_next.seeded = 1'b1;
                        inj_reach_next      = reach_last;
                    end
                    else
                    begin
                        inj_tok_next.valid = 1'b1;
                        if (region_size > best_reg)
                        begin
                            best_next = region_size;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = best_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inj_tok_reg   <= '0;
            out_valid_reg <= 1'b0;
            best_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            inj_tok_reg   <= inj_tok_next;
            out_valid_reg <= out_valid_next;
            best_reg      <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inj_reach_reg <= inj_reach_next;
        out_data_reg  <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = lcrs_pkg::OUT_DATA_W'(out_data_reg);

endmodule

>>> hdl/lcrs_cell.sv
// lcrs_cell: one graph node, holding its colour, neighbour row and flood bits
// passes the flood token on to the next cell each cycle; uses lcrs_pkg
`timescale 1ns / 1ps

module lcrs_cell #(
    parameter int NODE_COUNT = lcrs_pkg::NODE_COUNT_DEF,
    parameter int CNT_W      = $clog2(lcrs_pkg::NODE_COUNT_DEF + 1),
    parameter int IDX        = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lcrs_pkg::bus_t          bus,
    input  logic [NODE_COUNT-1:0]   wr_row,
    input  logic [NODE_COUNT-1:0]   mark_reach,
    input  lcrs_pkg::tok_t          tok_in,
    input  logic [NODE_COUNT-1:0]   reach_in,
    input  logic [CNT_W-1:0]        count_in,
    output lcrs_pkg::tok_t          tok_out,
    output logic [NODE_COUNT-1:0]   reach_out,
    output logic [CNT_W-1:0]        count_out
);

    localparam logic [NODE_COUNT-1:0] OWN_BIT  = NODE_COUNT'(1) << IDX;
    localparam logic [NODE_COUNT-1:0] LOW_MASK = OWN_BIT - NODE_COUNT'(1);

    logic [lcrs_pkg::COLOUR_W-1:0] colour_reg;
    logic [NODE_COUNT-1:0]         row_reg;
    logic                          member_reg;
    logic                          visited_reg;

    logic                  eligible;
    logic                  seed_here;
    logic                  active;
    logic [NODE_COUNT-1:0] reach_seeded;
    logic [NODE_COUNT-1:0] reach_next;
    logic                  changed_next;
    logic [CNT_W-1:0]      count_next;
    logic                  addressed;

    assign addressed = (int'(bus.node_index) == IDX);
    assign eligible  = member_reg & ~visited_reg;
    assign seed_here = tok_in.valid & ~tok_in.seeded & eligible;

    always_comb
    begin
        reach_seeded = reach_in | (seed_here ? OWN_BIT : '0);
        active       = tok_in.valid & reach_seeded[IDX] & eligible;
        reach_next   = active ? (reach_seeded | row_reg) : reach_seeded;
        // a new bit behind this cell needs one more pass
        changed_next = tok_in.changed |
                       (active & (|(row_reg & ~reach_seeded & LOW_MASK)));
        count_next   = count_in + CNT_W'(active);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg  <= '0;
            row_reg     <= '0;
            member_reg  <= 1'b0;
            visited_reg <= 1'b0;
            tok_out     <= '0;
        end
        else
        begin
            if (bus.wr_colour && addressed)
            begin
                colour_reg <= bus.colour;
            end
            if (bus.wr_row && addressed)
            begin
                row_reg <= wr_row & ~OWN_BIT;
            end
            if (bus.start)
            begin
                member_reg  <= (colour_reg == bus.colour);
                visited_reg <= 1'b0;
            end
            else if (bus.mark)
            begin
                visited_reg <= visited_reg | (mark_reach[IDX] & member_reg);
            end
            tok_out.valid   <= tok_in.valid;
            tok_out.seeded  <= tok_in.seeded | seed_here;
            tok_out.changed <= changed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reach_out <= reach_next;
        count_out <= count_next;
    end

endmodule

>>> tb/sv/region_size_checker.sv
// region_size_checker: watches both stream channels of largest_colour_region_size,
// predicts the region size for every accepted query and compares each result
// depends on lcrs_pkg only
`timescale 1ns / 1ps

module region_size_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // from bit 0: node_index[4:0], colour[7:5], neighbour_mask[39:8]
    input  logic [lcrs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // from bit 0: req_type[1:0]
    input  logic [lcrs_pkg::REQ_W-1:0]          s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // from bit 0: region_size[5:0]
    input  logic [lcrs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output int                                  fail_count,
    output int                                  outstanding
);

    import lcrs_pkg::*;

    logic [COLOUR_W-1:0]       colour_of [NODE_COUNT_DEF];
    logic [NODE_COUNT_DEF-1:0] row_of    [NODE_COUNT_DEF];
    logic [SIZE_W-1:0]         expected_sizes [$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        $display("region_size_checker: %s at %0t ns", what, $time);
        fail_count++;
    endtask

    // flood each region of the colour from the lowest unvisited node upwards
    function automatic logic [SIZE_W-1:0] largest_region(input logic [COLOUR_W-1:0] colour);
        logic [NODE_COUNT_DEF-1:0] members;
        logic [NODE_COUNT_DEF-1:0] seen;
        logic [NODE_COUNT_DEF-1:0] front;
        logic [NODE_COUNT_DEF-1:0] grow;
        int unsigned               count;
        int unsigned               best;
        members = '0;
        seen    = '0;
        best    = 0;
        for (int i = 0; i < NODE_COUNT_DEF; i++)
            members[INDEX_W'(i)] = (colour_of[INDEX_W'(i)] == colour);
        for (int s = 0; s < NODE_COUNT_DEF; s++)
        begin
            if (members[INDEX_W'(s)] && !seen[INDEX_W'(s)])
            begin
                front                = '0;
                front[INDEX_W'(s)]   = 1'b1;
                seen[INDEX_W'(s)]    = 1'b1;
                count                = 0;
                while (front != '0)
                begin
                    count += $countones(front);
                    grow = '0;
                    for (int j = 0; j < NODE_COUNT_DEF; j++)
                        if (front[INDEX_W'(j)])
                            grow |= row_of[INDEX_W'(j)];
                    grow  &= members & ~seen;
                    seen  |= grow;
                    front  = grow;
                end
                if (count > SIZE_SAT)
                    count = 32'(SIZE_SAT);
                if (count > best)
                    best = count;
            end
        end
        return best[SIZE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [INDEX_W-1:0]        node;
        logic [COLOUR_W-1:0]       colour;
        logic [NODE_COUNT_DEF-1:0] row;
        logic [SIZE_W-1:0]         want;
        logic [SIZE_W-1:0]         got;
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_COUNT_DEF; i++)
            begin
                colour_of[INDEX_W'(i)] = '0;
                row_of[INDEX_W'(i)]    = '0;
            end
            expected_sizes.delete();
            outstanding <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                node   = s_axis_tdata[INDEX_W-1:0];
                colour = s_axis_tdata[INDEX_W +: COLOUR_W];
                row    = s_axis_tdata[INDEX_W+COLOUR_W +: MASK_W];
                case (s_axis_tuser)
                    REQ_WR_COLOUR:
                        if (node < NODE_COUNT_DEF && colour < COLOUR_COUNT_DEF)
                            colour_of[node] = colour;
                    REQ_WR_ROW:
                        if (node < NODE_COUNT_DEF)
                        begin
                            // a node is never its own neighbour
                            row[node]    = 1'b0;
                            row_of[node] = row;
                        end
                    REQ_QUERY:
                        expected_sizes.push_back(colour < COLOUR_COUNT_DEF ?
                                                 largest_region(colour) : '0);
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[SIZE_W-1:0];
                if (expected_sizes.size() == 0)
                    report_mismatch($sformatf("result %0d with no query waiting", got));
                else
                begin
                    want = expected_sizes.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf("region_size %0d, expected %0d",
                                                  got, want));
                end
            end
            outstanding <= expected_sizes.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// tb_top: clock, reset and request stimulus for largest_colour_region_size
// depends on lcrs_pkg, largest_colour_region_size and region_size_checker
`timescale 1ns / 1ps

module tb_top;

    import lcrs_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int LIMIT_CYCLES   = 4_000_000;
    localparam int SETTLE_CYCLES  = 4 * NODE_COUNT_DEF;

    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_HALF, READY_RARE} ready_mode_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [REQ_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tready = 1'b0;
    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire [OUT_DATA_W-1:0]  m_axis_tdata;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int items_sent  = 0;

    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left  = 0;

    // rows as last written, so joins and cuts keep both ends in step
    logic [MASK_W-1:0] links [NODE_COUNT_DEF];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    largest_colour_region_size i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    region_size_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // result side stalls in stretches, each with its own pattern
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(64, 512);
        end
        mode_left = mode_left - 1;
        case (ready_mode)
            READY_ALWAYS: m_axis_tready <= 1'b1;
            READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
            READY_HALF:   m_axis_tready <= ($urandom_range(0, 1) != 0);
            default:      m_axis_tready <= (mode_left % 24 == 0);
        endcase
    end

    task automatic send_request(input logic [REQ_W-1:0]    req,
                                input logic [INDEX_W-1:0]  node,
                                input logic [COLOUR_W-1:0] colour,
                                input logic [MASK_W-1:0]   mask);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {mask, colour, node};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (req == REQ_WR_ROW)
        begin
            links[node]       = mask;
            links[node][node] = 1'b0;
        end
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    // cycles must be at least one, so tvalid is never lowered and raised in one step
    task automatic pause_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    function automatic logic [MASK_W-1:0] random_mask();
        logic [MASK_W-1:0] m;
        case ($urandom_range(0, 5))
            0:       m = '0;
            1:       m = '1;
            2:       m = $urandom();
            3:       m = $urandom() & $urandom() & $urandom();
            default:
            begin
                m = '0;
                m[INDEX_W'($urandom_range(0, MASK_W-1))] = 1'b1;
                m[INDEX_W'($urandom_range(0, MASK_W-1))] = 1'b1;
            end
        endcase
        return m;
    endfunction

    // a small palette most of the time so regions grow
    function automatic logic [COLOUR_W-1:0] random_colour();
        if ($urandom_range(0, 9) < 7)
            return COLOUR_W'($urandom_range(0, 2));
        return COLOUR_W'($urandom_range(0, COLOUR_COUNT_DEF-1));
    endfunction

    task automatic random_step();
        logic [INDEX_W-1:0] a;
        logic [INDEX_W-1:0] b;
        logic [MASK_W-1:0]  bit_a;
        logic [MASK_W-1:0]  bit_b;
        int                 pick;
        a        = INDEX_W'($urandom_range(0, NODE_COUNT_DEF-1));
        b        = INDEX_W'($urandom_range(0, NODE_COUNT_DEF-1));
        bit_a    = '0;
        bit_b    = '0;
        bit_a[a] = 1'b1;
        bit_b[b] = 1'b1;
        pick     = $urandom_range(0, 99);
        if (pick < 30)
            send_request(REQ_WR_COLOUR, a, random_colour(), $urandom());
        else if (pick < 50)
        begin
            // join both ways
            send_request(REQ_WR_ROW, a, COLOUR_W'($urandom()), links[a] | bit_b);
            send_request(REQ_WR_ROW, b, COLOUR_W'($urandom()), links[b] | bit_a);
        end
        else if (pick < 60)
        begin
            send_request(REQ_WR_ROW, a, COLOUR_W'($urandom()), links[a] & ~bit_b);
            send_request(REQ_WR_ROW, b, COLOUR_W'($urandom()), links[b] & ~bit_a);
        end
        else if (pick < 70)
            send_request(REQ_WR_ROW, a, COLOUR_W'($urandom()), random_mask());
        else if (pick < 97)
            send_request(REQ_QUERY, a, random_colour(), $urandom());
        else
            send_request(REQ_UNUSED, a, COLOUR_W'($urandom()), $urandom());
    endtask

    initial
    begin : stimulus
        int burst;
        for (int i = 0; i < NODE_COUNT_DEF; i++)
            links[INDEX_W'(i)] = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone nodes after reset, then a colour nobody has
        send_request(REQ_QUERY, 5'd0, 3'd0, '0);
        send_request(REQ_QUERY, 5'd31, 3'd7, '1);
        send_request(REQ_UNUSED, 5'd31, 3'd7, '1);
        // full row from node 0, own bit included: one region of every node
        send_request(REQ_WR_ROW, 5'd0, 3'd7, '1);
        send_request(REQ_QUERY, 5'd0, 3'd0, '0);
        send_request(REQ_WR_ROW, 5'd0, 3'd0, '0);
        // one-way link 31 -> 30, seed 30 comes first
        send_request(REQ_WR_COLOUR, 5'd31, 3'd7, '1);
        send_request(REQ_WR_ROW, 5'd31, 3'd7, 32'h4000_0000);
        send_request(REQ_WR_COLOUR, 5'd30, 3'd7, '0);
        send_request(REQ_QUERY, 5'd0, 3'd7, '0);
        send_request(REQ_WR_ROW, 5'd30, 3'd0, 32'h8000_0000);
        send_request(REQ_QUERY, 5'd0, 3'd7, '0);
        send_request(REQ_WR_COLOUR, 5'd0, 3'd7, '0);
        send_request(REQ_WR_ROW, 5'd0, 3'd0, 32'h4000_0001);
        send_request(REQ_QUERY, 5'd0, 3'd7, '0);
        send_request(REQ_QUERY, 5'd0, 3'd0, '0);
        pause_sender(3);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                burst = $urandom_range(40, 120);
            else
                burst = $urandom_range(1, 16);
            repeat (burst)
                random_step();
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 12));
        end
        pause_sender(1);

        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
